/* rtl/tlprc_pkg.sv */
// shared types and constants for the tail light pair row counter
// no dependencies
`default_nettype none

package tlprc_pkg;

    localparam int FIELD_W   = 10;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 11;
    localparam int SEGS      = 4;
    localparam int CLASSES   = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W = 1;

    // segment width: (w + 2) / 5 as a reciprocal multiply, exact below 16384
    localparam int SPAN_W     = FIELD_W + 1;
    localparam int DIV5_W     = 14;
    localparam int DIV5_SHIFT = 16;
    localparam int D_W        = 8;
    localparam logic [DIV5_W-1:0] DIV5_MUL = 14'd13108;

    // signed width for segment bounds
    localparam int POS_W = FIELD_W + 2;

    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

    localparam logic [1:0] CLS_SHADOW = 2'd0;
    localparam logic [1:0] CLS_NONE   = 2'd1;
    localparam logic [1:0] CLS_LIGHT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MASK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_MASK = 1'b1;

    typedef struct packed {
        logic [1:0]      cls;
        logic [SEGS-1:0] hits;
        logic            eor;
        logic            eob;
    } q_entry_t;

endpackage

`default_nettype wire

/* rtl/tlprc_if.sv */
// channel interfaces: pixel stream in, row result out
// depends on tlprc_pkg
`default_nettype none

interface tlprc_pix_if
    import tlprc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0]  info_byte;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] left_bound;
    logic [FIELD_W-1:0] right_bound;
    logic              end_of_row;
    logic              end_of_box;

    modport source (output valid, info_byte, column, left_bound, right_bound,
                    end_of_row, end_of_box, input ready);
    modport sink   (input valid, info_byte, column, left_bound, right_bound,
                    end_of_row, end_of_box, output ready);
endinterface

interface tlprc_res_if
    import tlprc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             row_is_pair;
    logic [CNT_W-1:0] pair_rows;
    logic             box_done;

    modport source (output valid, row_is_pair, pair_rows, box_done, input ready);
    modport sink   (input valid, row_is_pair, pair_rows, box_done, output ready);
endinterface

`default_nettype wire

/* rtl/tail_light_pair_row_counter.sv */
// top level of the tail light pair row counter
// depends on tlprc_pkg, tlprc_if, tlprc_front, tlprc_fifo, tlprc_back
//
//  channel | dir | transaction              | fields
//  pix     | in  | one pixel of a box row   | info_byte column left_bound right_bound
//          |     |                          | end_of_row end_of_box
//  res     | out | one finished row         | row_is_pair pair_rows box_done
//  cfg     | in  | register write (cfg_we)  | cfg_index cfg_data
//
// one pixel per cycle if res keeps up; the front is two register stages and the queue adds one,
// and the back end registers a row result for res once the last pixel of the row is popped.
// the counter update and vote of a row end share one cycle in the back end.
// asynchronous reset clears counters and queue and sets the masks (light 1, shadow 2).
// a stalled result stalls the back end only at a row end; the queue keeps the front running until full.
`default_nettype none

module tail_light_pair_row_counter
    import tlprc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    tlprc_pix_if.sink                 pix,
    tlprc_res_if.source               res
);

    localparam int CAP_INT = (MAX_WIDTH < int'(CNT_MAX)) ? MAX_WIDTH : int'(CNT_MAX);
    localparam logic [CNT_W-1:0] PAIR_CAP = CNT_W'(CAP_INT);

    logic     fq_valid;
    logic     fq_ready;
    q_entry_t fq_entry;
    logic     qb_valid;
    logic     qb_ready;
    q_entry_t qb_entry;

    tlprc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .q_valid   (fq_valid),
        .q_entry   (fq_entry),
        .q_ready   (fq_ready)
    );

    tlprc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_entry  (fq_entry),
        .in_ready  (fq_ready),
        .out_valid (qb_valid),
        .out_entry (qb_entry),
        .out_ready (qb_ready)
    );

    tlprc_back #(
        .PAIR_CAP (PAIR_CAP)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_entry (qb_entry),
        .q_ready (qb_ready),
        .res     (res)
    );

endmodule

`default_nettype wire

/* rtl/tlprc_front.sv */
// front end: config registers, pixel classing, segment width and segment hits
// two register stages; depends on tlprc_pkg and tlprc_if
`default_nettype none

module tlprc_front
    import tlprc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    tlprc_pix_if.sink                 pix,
    output logic                      q_valid,
    output q_entry_t                  q_entry,
    input  wire logic                 q_ready
);

    logic [BYTE_W-1:0] light_mask_reg;
    logic [BYTE_W-1:0] shadow_mask_reg;

    logic               s1_valid_reg;
    logic [1:0]         s1_cls_reg;
    logic [FIELD_W-1:0] s1_col_reg;
    logic [FIELD_W-1:0] s1_lb_reg;
    logic [FIELD_W-1:0] s1_rb_reg;
    logic [D_W-1:0]     s1_d_reg;
    logic               s1_eor_reg;
    logic               s1_eob_reg;

    logic     s2_valid_reg;
    q_entry_t s2_entry_reg;

    logic                     s1_ready;
    logic                     s2_ready;
    logic [1:0]               cls_in;
    logic [SPAN_W-1:0]        span;
    logic [SPAN_W+DIV5_W-1:0] prod;
    logic [D_W-1:0]           d_in;

    logic signed [POS_W-1:0] col_s;
    logic signed [POS_W-1:0] lb_s;
    logic signed [POS_W-1:0] rb_s;
    logic signed [POS_W-1:0] d_s;
    logic [SEGS-1:0]         hits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_mask_reg  <= 8'd1;
            shadow_mask_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIGHT_MASK:  light_mask_reg  <= cfg_data;
                CFG_SHADOW_MASK: shadow_mask_reg <= cfg_data;
            endcase
        end
    end

    assign s2_ready  = !s2_valid_reg || q_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pix.ready = s1_ready;

    always_comb
    begin
        if ((pix.info_byte & light_mask_reg) == light_mask_reg)
            cls_in = CLS_LIGHT;
        else if ((pix.info_byte & shadow_mask_reg) == shadow_mask_reg)
            cls_in = CLS_SHADOW;
        else
            cls_in = CLS_NONE;
    end

    assign span = {1'b0, pix.right_bound} - {1'b0, pix.left_bound} + SPAN_W'(3);
    assign prod = span * DIV5_MUL;
    assign d_in = (pix.right_bound >= pix.left_bound) ? prod[DIV5_SHIFT +: D_W] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pix.valid)
        begin
            s1_cls_reg <= cls_in;
            s1_col_reg <= pix.column;
            s1_lb_reg  <= pix.left_bound;
            s1_rb_reg  <= pix.right_bound;
            s1_d_reg   <= d_in;
            s1_eor_reg <= pix.end_of_row;
            s1_eob_reg <= pix.end_of_box;
        end
    end

    // segment bounds may go below zero on narrow boxes
    assign col_s = signed'({2'b00, s1_col_reg});
    assign lb_s  = signed'({2'b00, s1_lb_reg});
    assign rb_s  = signed'({2'b00, s1_rb_reg});
    assign d_s   = signed'({{(POS_W-D_W){1'b0}}, s1_d_reg});

    assign hits[0] = (col_s >= lb_s) && (col_s <= lb_s + d_s);
    assign hits[1] = (col_s >= lb_s + d_s + POS_W'(1)) && (col_s <= lb_s + d_s + d_s);
    assign hits[2] = (col_s >= rb_s - d_s - d_s) && (col_s <= rb_s - d_s - POS_W'(1));
    assign hits[3] = (col_s >= rb_s - d_s) && (col_s <= rb_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_entry_reg.cls  <= s1_cls_reg;
            s2_entry_reg.hits <= hits;
            s2_entry_reg.eor  <= s1_eor_reg;
            s2_entry_reg.eob  <= s1_eob_reg;
        end
    end

    assign q_valid = s2_valid_reg;
    assign q_entry = s2_entry_reg;

endmodule

`default_nettype wire

/* rtl/tlprc_fifo.sv */
// short queue of classified pixels between front and back
// depends on tlprc_pkg
`default_nettype none

module tlprc_fifo
    import tlprc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  q_entry_t  in_entry,
    output logic      in_ready,
    output logic      out_valid,
    output q_entry_t  out_entry,
    input  wire logic out_ready
);

    q_entry_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_entry;
    end

endmodule

`default_nettype wire

/* rtl/tlprc_back.sv */
// back end: segment class counters, row vote, pair row count, result register
// depends on tlprc_pkg and tlprc_if
`default_nettype none

module tlprc_back
    import tlprc_pkg::*;
#(
    parameter logic [CNT_W-1:0] PAIR_CAP = 11'd1024
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  q_entry_t  q_entry,
    output logic      q_ready,
    tlprc_res_if.source res
);

    logic [CNT_W-1:0] cnt_reg  [SEGS][CLASSES];
    logic [CNT_W-1:0] cnt_next [SEGS][CLASSES];
    logic [CNT_W-1:0] pc_reg;
    logic [CNT_W-1:0] pc_inc;
    logic             out_valid_reg;
    logic             out_pair_reg;
    logic [CNT_W-1:0] out_rows_reg;
    logic             out_done_reg;

    logic [SEGS-1:0]  vote_light;
    logic [CNT_W:0]   li;
    logic             pair;
    logic             pop;
    logic             row_end;

    always_comb
    begin
        for (int s = 0; s < SEGS; s++)
        begin
            for (int c = 0; c < CLASSES; c++)
            begin
                cnt_next[s][c] = cnt_reg[s][c];
                if (q_entry.hits[s] && (q_entry.cls == 2'(c)) && (cnt_reg[s][c] != CNT_MAX))
                    cnt_next[s][c] = cnt_reg[s][c] + CNT_W'(1);
            end
        end
    end

    // edge segments count light twice; ties go to light
    always_comb
    begin
        li = '0;
        for (int s = 0; s < SEGS; s++)
        begin
            if (s == 0 || s == SEGS - 1)
                li = {cnt_next[s][CLS_LIGHT], 1'b0};
            else
                li = {1'b0, cnt_next[s][CLS_LIGHT]};
            vote_light[s] = (li >= {1'b0, cnt_next[s][CLS_NONE]})
                         && (li >= {1'b0, cnt_next[s][CLS_SHADOW]});
        end
    end

    assign pair   = vote_light[0] && !vote_light[1] && !vote_light[2] && vote_light[3];
    assign pc_inc = (pair && (pc_reg < PAIR_CAP)) ? pc_reg + CNT_W'(1) : pc_reg;

    assign q_ready = !q_entry.eor || !out_valid_reg || res.ready;
    assign pop     = q_valid && q_ready;
    assign row_end = pop && q_entry.eor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SEGS; s++)
                for (int c = 0; c < CLASSES; c++)
                    cnt_reg[s][c] <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                for (int s = 0; s < SEGS; s++)
                    for (int c = 0; c < CLASSES; c++)
                        cnt_reg[s][c] <= q_entry.eor ? '0 : cnt_next[s][c];
            end
            if (row_end)
                pc_reg <= q_entry.eob ? '0 : pc_inc;
            if (row_end)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_end)
        begin
            out_pair_reg <= pair;
            out_rows_reg <= pc_inc;
            out_done_reg <= q_entry.eob;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.row_is_pair = out_pair_reg;
    assign res.pair_rows   = out_rows_reg;
    assign res.box_done    = out_done_reg;

endmodule

`default_nettype wire

/* rtl/tlprc_checker.sv */
// port level checks on the result channel of the tail light pair row counter
// depends on tlprc_pkg; bound to tail_light_pair_row_counter
`default_nettype none

module tlprc_checker
    import tlprc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire logic             row_is_pair,
    input wire logic [CNT_W-1:0] pair_rows,
    input wire logic             box_done
);

    localparam int CAP_INT = (MAX_WIDTH < int'(CNT_MAX)) ? MAX_WIDTH : int'(CNT_MAX);
    localparam logic [CNT_W-1:0] PAIR_CAP = CNT_W'(CAP_INT);

    logic [CNT_W-1:0] base_reg;
    logic [CNT_W-1:0] exp_rows;

    // running count seen so far in the current box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (res_valid && res_ready)
            base_reg <= box_done ? '0 : pair_rows;
    end

    assign exp_rows = (row_is_pair && (base_reg < PAIR_CAP)) ? base_reg + CNT_W'(1)
                                                             : base_reg;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(pair_rows) && $stable(row_is_pair)
                                    && $stable(box_done))
        else $error("result changed while stalled");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pair_rows == exp_rows)
        else $error("pair row count does not follow the row flags");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result shown straight after reset");

endmodule

bind tail_light_pair_row_counter tlprc_checker #(
    .MAX_WIDTH (MAX_WIDTH)
) u_tlprc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .row_is_pair (res.row_is_pair),
    .pair_rows   (res.pair_rows),
    .box_done    (res.box_done)
);

`default_nettype wire
